// ===== design/bpc_pkg.sv =====
package bpc_pkg;

   localparam int CFG_WIDTH  = 16;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_WIDTH = 4;

   typedef enum logic [1:0] {
      REG_DEBOUNCE  = 2'd0,
      REG_LONG      = 2'd1,
      REG_TIMEOUT   = 2'd2,
      REG_RELEASE   = 2'd3
   } reg_index_type;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [CFG_WIDTH-1:0] LONG_RESET     = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET  = 16'd500;
   localparam logic                 RELEASE_RESET  = 1'b0;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ms;
      logic [CFG_WIDTH-1:0] long_press_ms;
      logic [CFG_WIDTH-1:0] repeat_timeout_ms;
      logic                 short_on_release;
   } cfg_type;

endpackage

// ===== design/bpc_csr.sv =====
module bpc_csr
   import bpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_WIDTH-1:0] csr_paddr,
   input  logic [DATA_WIDTH-1:0] csr_pwdata,
   output logic [DATA_WIDTH-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_DEBOUNCE: cfg_in.debounce_ms       = csr_pwdata[CFG_WIDTH-1:0];
            REG_LONG:     cfg_in.long_press_ms     = csr_pwdata[CFG_WIDTH-1:0];
            REG_TIMEOUT:  cfg_in.repeat_timeout_ms = csr_pwdata[CFG_WIDTH-1:0];
            REG_RELEASE:  cfg_in.short_on_release  = csr_pwdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_DEBOUNCE: csr_prdata = DATA_WIDTH'(cfg_ff.debounce_ms);
         REG_LONG:     csr_prdata = DATA_WIDTH'(cfg_ff.long_press_ms);
         REG_TIMEOUT:  csr_prdata = DATA_WIDTH'(cfg_ff.repeat_timeout_ms);
         REG_RELEASE:  csr_prdata = DATA_WIDTH'(cfg_ff.short_on_release);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms       <= DEBOUNCE_RESET;
         cfg_ff.long_press_ms     <= LONG_RESET;
         cfg_ff.repeat_timeout_ms <= TIMEOUT_RESET;
         cfg_ff.short_on_release  <= RELEASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/bpc_engine.sv =====
module bpc_engine
   import bpc_pkg::*;
#(
   parameter int TIME_WIDTH  = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   fire,
   input  logic                   kind,
   input  logic                   pin_down,
   input  logic [TIME_WIDTH-1:0]  now_ms,
   input  logic                   clear_short,
   input  logic                   clear_long,
   input  logic                   clear_count,
   output logic                   held,
   output logic                   short_seen,
   output logic                   long_seen,
   output logic [COUNT_WIDTH-1:0] press_count
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic                   down_ff, down_in;
   logic                   wait_ff, wait_in;
   logic                   short_ff, short_in;
   logic                   long_ff, long_in;
   logic                   done_ff, done_in;
   logic [TIME_WIDTH-1:0]  down_time_ff, down_time_in;
   logic [TIME_WIDTH-1:0]  rel_time_ff, rel_time_in;
   logic [TIME_WIDTH-1:0]  last_time_ff, last_time_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic [TIME_WIDTH-1:0]  e_now_rel, e_rel_down, e_now_down, e_now_last, e_rel_last;
   logic [TIME_WIDTH-1:0]  debounce_t, long_t, timeout_t;
   logic [TIME_WIDTH-1:0]  note_gap, final_gap, hold_gap;
   logic                   do_press, do_release, cancel, arm;
   logic                   note_rel, note_press, note;
   logic                   mid_down, mid_wait, mid_done, long_fire;
   logic [COUNT_WIDTH-1:0] mid_count, out_count;
   logic                   out_short, out_long;

   assign e_now_rel  = now_ms - rel_time_ff;
   assign e_rel_down = rel_time_ff - down_time_ff;
   assign e_now_down = now_ms - down_time_ff;
   assign e_now_last = now_ms - last_time_ff;
   assign e_rel_last = rel_time_ff - last_time_ff;
   assign debounce_t = TIME_WIDTH'(cfg.debounce_ms);
   assign long_t     = TIME_WIDTH'(cfg.long_press_ms);
   assign timeout_t  = TIME_WIDTH'(cfg.repeat_timeout_ms);

   always_comb begin
      do_press   = 1'b0;
      do_release = 1'b0;
      cancel     = 1'b0;
      arm        = 1'b0;
      if (!kind) begin
         if (pin_down) begin
            if (!down_ff) begin
               do_press = 1'b1;
            end else if (wait_ff) begin
               if (e_now_rel >= debounce_t) begin
                  do_release = 1'b1;
                  do_press   = 1'b1;
               end else begin
                  cancel = 1'b1;
               end
            end
         end else if (down_ff && !wait_ff) begin
            arm = 1'b1;
         end
      end else if (down_ff && wait_ff) begin
         if (pin_down) begin
            if (e_now_rel >= debounce_t) begin
               do_release = 1'b1;
               do_press   = 1'b1;
            end else begin
               cancel = 1'b1;
            end
         end else if (e_now_rel >= debounce_t) begin
            do_release = 1'b1;
         end
      end

      note_rel   = do_release && cfg.short_on_release && !done_ff && (e_rel_down < long_t);
      note_press = do_press && !cfg.short_on_release;
      note       = note_rel || note_press;
      note_gap   = note_rel ? e_rel_last : e_now_last;

      mid_count = count_ff;
      if (note) begin
         if (count_ff == '0 || note_gap > timeout_t) begin
            mid_count = COUNT_WIDTH'(1);
         end else if (count_ff < COUNT_MAX) begin
            mid_count = count_ff + COUNT_WIDTH'(1);
         end
      end

      mid_down = do_press ? 1'b1 : (do_release ? 1'b0 : down_ff);
      mid_wait = (do_press || do_release || cancel) ? 1'b0 : (arm ? 1'b1 : wait_ff);
      mid_done = (do_press || do_release) ? 1'b0 : done_ff;
      hold_gap = do_press ? '0 : e_now_down;

      long_fire = kind && mid_down && !mid_wait && pin_down && !mid_done &&
                  (hold_gap >= long_t);

      out_short = short_ff || note;
      out_long  = long_ff || long_fire;
      if (long_fire) begin
         mid_count = '0;
      end

      if (note) begin
         final_gap = note_rel ? e_now_rel : '0;
      end else begin
         final_gap = e_now_last;
      end
      out_count = mid_count;
      if (mid_count != '0 && final_gap > timeout_t) begin
         out_count = '0;
      end

      down_in      = down_ff;
      wait_in      = wait_ff;
      done_in      = done_ff;
      short_in     = short_ff;
      long_in      = long_ff;
      count_in     = count_ff;
      down_time_in = down_time_ff;
      rel_time_in  = rel_time_ff;
      last_time_in = last_time_ff;
      if (fire) begin
         down_in      = mid_down;
         wait_in      = mid_wait;
         done_in      = mid_done || long_fire;
         short_in     = out_short && !clear_short;
         long_in      = out_long && !clear_long;
         count_in     = clear_count ? '0 : out_count;
         down_time_in = do_press ? now_ms : down_time_ff;
         rel_time_in  = arm ? now_ms : rel_time_ff;
         last_time_in = note ? (note_rel ? rel_time_ff : now_ms) : last_time_ff;
      end
   end

   assign held        = mid_down;
   assign short_seen  = out_short;
   assign long_seen   = out_long;
   assign press_count = out_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff      <= 1'b0;
         wait_ff      <= 1'b0;
         done_ff      <= 1'b0;
         short_ff     <= 1'b0;
         long_ff      <= 1'b0;
         count_ff     <= '0;
         down_time_ff <= '0;
         rel_time_ff  <= '0;
         last_time_ff <= '0;
      end else begin
         down_ff      <= down_in;
         wait_ff      <= wait_in;
         done_ff      <= done_in;
         short_ff     <= short_in;
         long_ff      <= long_in;
         count_ff     <= count_in;
         down_time_ff <= down_time_in;
         rel_time_ff  <= rel_time_in;
         last_time_ff <= last_time_in;
      end
   end

   a_wait_needs_down: assert property (@(posedge clock) disable iff (reset)
      wait_ff |-> down_ff)
      else $error("A release is pending while the button is up.");

   a_done_needs_down: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> down_ff)
      else $error("A long press is marked while the button is up.");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      fire && clear_count |=> count_ff == '0)
      else $error("The press count survived a clear request.");

endmodule

// ===== design/button_press_classifier_core.sv =====
// Debounced button classifier. Each accepted word is a timestamped pin event
// or poll; each one yields exactly one result word with the debounced level,
// the sticky short and long press flags and the consecutive press count. A
// word is held in the input register and evaluated there by the classifier,
// and its result sits in the output register until taken, so one word can be
// accepted every clock cycle; throughput is limited only by stall on the
// result side. The user must write configuration through the APB-style port
// only while no word is in flight; the block itself does not enforce this.
module button_press_classifier_core
   import bpc_pkg::*;
#(
   parameter int TIME_WIDTH  = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic                   req_pin_down,
   input  logic [TIME_WIDTH-1:0]  req_now_ms,
   input  logic                   req_clear_short,
   input  logic                   req_clear_long,
   input  logic                   req_clear_count,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_held,
   output logic                   rsp_short_seen,
   output logic                   rsp_long_seen,
   output logic [COUNT_WIDTH-1:0] rsp_press_count,

   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [DATA_WIDTH-1:0]  csr_pwdata,
   output logic [DATA_WIDTH-1:0]  csr_prdata,
   output logic                   csr_pready
);

   cfg_type cfg;

   logic                   in_valid_ff, in_valid_in;
   logic                   kind_ff, pin_ff, clr_short_ff, clr_long_ff, clr_count_ff;
   logic [TIME_WIDTH-1:0]  now_ff;
   logic                   out_valid_ff, out_valid_in;
   logic                   held_ff, short_ff, long_ff;
   logic [COUNT_WIDTH-1:0] count_ff;

   logic                   advance, fire, take;
   logic                   held_c, short_c, long_c;
   logic [COUNT_WIDTH-1:0] count_c;

   bpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   bpc_engine #(
      .TIME_WIDTH  (TIME_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .fire        (fire),
      .kind        (kind_ff),
      .pin_down    (pin_ff),
      .now_ms      (now_ff),
      .clear_short (clr_short_ff),
      .clear_long  (clr_long_ff),
      .clear_count (clr_count_ff),
      .held        (held_c),
      .short_seen  (short_c),
      .long_seen   (long_c),
      .press_count (count_c)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff      <= req_kind;
         pin_ff       <= req_pin_down;
         now_ff       <= req_now_ms;
         clr_short_ff <= req_clear_short;
         clr_long_ff  <= req_clear_long;
         clr_count_ff <= req_clear_count;
      end
      if (fire) begin
         held_ff  <= held_c;
         short_ff <= short_c;
         long_ff  <= long_c;
         count_ff <= count_c;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_held        = held_ff;
   assign rsp_short_seen  = short_ff;
   assign rsp_long_seen   = long_ff;
   assign rsp_press_count = count_ff;

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && rsp_stall |-> req_stall && !fire)
      else $error("A word advanced while the result register was blocked.");

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("An evaluated word produced no result.");

endmodule
